FILE: hw/rtl/lpsr_pkg.sv
// Shared types and constants of the LED panel shape rasterizer.
package lpsr_pkg;

  localparam int unsigned MaxSide   = 8;
  localparam int unsigned GlyphRows = 5;
  localparam int unsigned GlyphCols = 3;
  localparam int unsigned SideW     = 4;
  localparam int unsigned GlyphW    = GlyphRows * GlyphCols;

  typedef enum logic [1:0] {
    ModeFill   = 2'd0,
    ModeBorder = 2'd1,
    ModeCircle = 2'd2,
    ModeGlyph  = 2'd3
  } mode_e;

  // One classified draw command as it waits for the pixel walker.
  typedef struct packed {
    mode_e              mode;
    logic [SideW-1:0]   rows;
    logic [SideW-1:0]   cols;
    logic [SideW-1:0]   half;
    logic [7:0]         base_x;
    logic [7:0]         base_y;
    logic [2:0]         front_color;
    logic [2:0]         back_color;
    logic [GlyphW-1:0]  glyph_bits;
    logic               rotated;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_status_t;

endpackage

FILE: hw/rtl/lpsr_front.sv
// Command front end: saturates extents, works out the walk bounds and drops empty shapes.
module lpsr_front (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                mode_i,
  input  logic signed [7:0]         anchor_x_i,
  input  logic signed [7:0]         anchor_y_i,
  input  logic [3:0]                extent_h_i,
  input  logic [3:0]                extent_w_i,
  input  logic [2:0]                front_color_i,
  input  logic [2:0]                back_color_i,
  input  logic [14:0]               glyph_bits_i,
  input  logic                      rotated_i,
  input  lpsr_pkg::q_status_t       q_status_i,
  output logic                      push_o,
  output lpsr_pkg::cmd_t            cmd_o
);
  import lpsr_pkg::*;

  logic [SideW-1:0] eh_sat;
  logic [SideW-1:0] ew_sat;
  logic [SideW-1:0] half;
  mode_e            mode;
  logic             drop;

  assign mode   = mode_e'(mode_i);
  assign eh_sat = (extent_h_i > SideW'(MaxSide)) ? SideW'(MaxSide) : extent_h_i;
  assign ew_sat = (extent_w_i > SideW'(MaxSide)) ? SideW'(MaxSide) : extent_w_i;
  assign half   = eh_sat >> 1;

  always_comb begin
    cmd_o             = '0;
    cmd_o.mode        = mode;
    cmd_o.half        = half;
    cmd_o.front_color = front_color_i;
    cmd_o.back_color  = back_color_i;
    cmd_o.glyph_bits  = glyph_bits_i;
    cmd_o.rotated     = rotated_i;
    cmd_o.base_x      = anchor_x_i;
    cmd_o.base_y      = anchor_y_i;
    case (mode)
      ModeFill, ModeBorder: begin
        cmd_o.rows = eh_sat;
        cmd_o.cols = ew_sat;
      end
      ModeCircle: begin
        cmd_o.rows   = eh_sat;
        cmd_o.cols   = eh_sat;
        cmd_o.base_x = anchor_x_i - {4'd0, half};
        cmd_o.base_y = anchor_y_i - {4'd0, half};
      end
      ModeGlyph: begin
        cmd_o.rows = SideW'(GlyphRows);
        cmd_o.cols = SideW'(GlyphCols);
      end
      default: begin
        cmd_o.rows = '0;
        cmd_o.cols = '0;
      end
    endcase
  end

  // Shapes with a zero side cause no writes: take the command and drop it.
  assign drop       = (cmd_o.rows == '0) || (cmd_o.cols == '0);
  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && in_ready_o && !drop;

endmodule

FILE: hw/rtl/lpsr_queue.sv
// Short command queue between the front end and the pixel walker.
module lpsr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  lpsr_pkg::cmd_t                cmd_i,
  input  logic                          pop_i,
  output lpsr_pkg::cmd_t                cmd_o,
  output lpsr_pkg::q_status_t           status_o,
  output logic [$clog2(DEPTH+1)-1:0]    count_o
);
  import lpsr_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH+1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign status_o.full  = (count_q == CntW'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign count_o        = count_q;
  assign cmd_o          = mem_q[rd_ptr_q];

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: hw/rtl/lpsr_back.sv
// Pixel walker: steps one command row by row and emits mapped pixel writes.
module lpsr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [6:0]             panel_columns_i,
  input  lpsr_pkg::q_status_t    q_status_i,
  input  lpsr_pkg::cmd_t         q_cmd_i,
  output lpsr_pkg::back_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   upper_half_o,
  output logic [1:0]             buffer_col_o,
  output logic [7:0]             buffer_row_o,
  output logic [2:0]             pixel_color_o,
  output logic                   last_o
);
  import lpsr_pkg::*;

  cmd_t             cmd_q, cmd_d;
  logic             busy_q, busy_d;
  logic [SideW-1:0] row_q, row_d;
  logic [SideW-1:0] col_q, col_d;
  logic             out_valid_q, out_valid_d;
  logic             upper_q, upper_d;
  logic [1:0]       bcol_q, bcol_d;
  logic [7:0]       brow_q, brow_d;
  logic [2:0]       color_q, color_d;
  logic             last_q, last_d;

  logic             pop;
  logic             step;
  logic             row_end;
  logic             col_end;
  logic             emit;
  logic [7:0]       px;
  logic [7:0]       py;
  logic [2:0]       color;
  logic signed [6:0] dr;
  logic signed [6:0] dc;
  logic [6:0]       dist2;
  logic [6:0]       rad2;
  logic [3:0]       glyph_idx;
  logic signed [7:0] ys;
  logic signed [7:0] seg;
  logic [7:0]       bitpos;
  logic [7:0]       c2;
  logic [7:0]       row_fold;

  assign pop     = !busy_q && !q_status_i.empty;
  assign step    = busy_q && (!out_valid_q || out_ready_i);
  assign row_end = (row_q == cmd_q.rows - 1'b1);
  assign col_end = (col_q == cmd_q.cols - 1'b1);

  assign status_o.busy = busy_q;
  assign status_o.pop  = pop;

  // Pixel position.
  always_comb begin
    if (cmd_q.mode == ModeGlyph && cmd_q.rotated) begin
      px = cmd_q.base_x - {4'd0, col_q};
      py = cmd_q.base_y + {4'd0, row_q};
    end else begin
      px = cmd_q.base_x + {4'd0, row_q};
      py = cmd_q.base_y + {4'd0, col_q};
    end
  end

  // Circle distance test on small values.
  assign dr        = $signed({3'b0, row_q}) - $signed({3'b0, cmd_q.half});
  assign dc        = $signed({3'b0, col_q}) - $signed({3'b0, cmd_q.half});
  assign dist2     = 7'(dr * dr) + 7'(dc * dc);
  assign rad2      = {3'd0, cmd_q.half} * {3'd0, cmd_q.half};
  assign glyph_idx = 4'({row_q, 1'b0}) + row_q + 4'd2 - col_q;

  always_comb begin
    emit  = 1'b1;
    color = cmd_q.front_color;
    case (cmd_q.mode)
      ModeFill: begin
        color = cmd_q.front_color;
      end
      ModeBorder: begin
        emit = (row_q == '0) || row_end || (col_q == '0) || col_end;
      end
      ModeCircle: begin
        color = (dist2 <= rad2) ? cmd_q.front_color : cmd_q.back_color;
      end
      ModeGlyph: begin
        color = cmd_q.glyph_bits[glyph_idx] ? cmd_q.front_color : 3'd0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Row fold: segment and bit by truncating division of the signed row by eight.
  assign ys     = $signed(py);
  assign seg    = (ys + (ys[7] ? 8'sd7 : 8'sd0)) >>> 3;
  assign bitpos = py - {seg[4:0], 3'd0};
  assign c2     = {panel_columns_i, 1'b0};
  assign row_fold = px[2] ? (c2 - 8'd1 - py - {seg[4:0], 3'd0})
                          : (c2 - 8'd16 - {seg[3:0], 4'd0} + bitpos);

  always_comb begin
    cmd_d       = cmd_q;
    busy_d      = busy_q;
    row_d       = row_q;
    col_d       = col_q;
    out_valid_d = out_valid_q && !out_ready_i;
    upper_d     = upper_q;
    bcol_d      = bcol_q;
    brow_d      = brow_q;
    color_d     = color_q;
    last_d      = last_q;
    if (pop) begin
      cmd_d  = q_cmd_i;
      busy_d = 1'b1;
      row_d  = '0;
      col_d  = '0;
    end
    if (step) begin
      if (emit) begin
        out_valid_d = 1'b1;
        upper_d     = px[3];
        bcol_d      = px[1:0];
        brow_d      = row_fold;
        color_d     = color;
        last_d      = row_end && col_end;
      end
      if (col_end) begin
        col_d = '0;
        row_d = row_q + 1'b1;
        if (row_end) begin
          busy_d = 1'b0;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      row_q       <= row_d;
      col_q       <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    upper_q <= upper_d;
    bcol_q  <= bcol_d;
    brow_q  <= brow_d;
    color_q <= color_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign upper_half_o  = upper_q;
  assign buffer_col_o  = bcol_q;
  assign buffer_row_o  = brow_q;
  assign pixel_color_o = color_q;
  assign last_o        = last_q;

endmodule

FILE: hw/rtl/led_panel_shape_rasterizer.sv
// Top level of the LED panel shape rasterizer.
//
// Input channel (in_valid_i/in_ready_o) takes one draw command per
// transaction: filled rectangle, rectangle border, circle or 3x5 glyph.
// Output channel (out_valid_o/out_ready_i) gives one pixel write per
// transaction, already mapped to buffer half, column and folded row;
// last_o marks the final write of a command.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes the panel column
// count; it is always ready and should only be written while idle.
// A command sits in a queue of QUEUE_DEPTH entries until the pixel walker
// picks it up. The walker loads the command and then steps through each
// position of its rows x cols grid (at most 64; border mode walks the
// interior too without emitting). Commands with a zero side emit nothing.
// An idle block's first write passes queue, command and output registers.
// When the receiver stalls, the output register holds its write, the walker
// halts and the queue fills, after which in_ready_o drops.
// Reset empties the queue and walker and sets the column count to 16.
module led_panel_shape_rasterizer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [6:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic signed [7:0] anchor_x_i,
  input  logic signed [7:0] anchor_y_i,
  input  logic [3:0]        extent_h_i,
  input  logic [3:0]        extent_w_i,
  input  logic [2:0]        front_color_i,
  input  logic [2:0]        back_color_i,
  input  logic [14:0]       glyph_bits_i,
  input  logic              rotated_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              upper_half_o,
  output logic [1:0]        buffer_col_o,
  output logic [7:0]        buffer_row_o,
  output logic [2:0]        pixel_color_o,
  output logic              last_o
);
  import lpsr_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH+1);

  logic [6:0]      panel_columns_q;
  logic            push;
  cmd_t            front_cmd;
  cmd_t            head_cmd;
  q_status_t       q_status;
  back_status_t    back_status;
  logic [CntW-1:0] q_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_columns_q <= 7'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      panel_columns_q <= cfg_data_i;
    end
  end

  lpsr_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .anchor_x_i    (anchor_x_i),
    .anchor_y_i    (anchor_y_i),
    .extent_h_i    (extent_h_i),
    .extent_w_i    (extent_w_i),
    .front_color_i (front_color_i),
    .back_color_i  (back_color_i),
    .glyph_bits_i  (glyph_bits_i),
    .rotated_i     (rotated_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  lpsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (front_cmd),
    .pop_i    (back_status.pop),
    .cmd_o    (head_cmd),
    .status_o (q_status),
    .count_o  (q_count)
  );

  lpsr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .panel_columns_i (panel_columns_q),
    .q_status_i      (q_status),
    .q_cmd_i         (head_cmd),
    .status_o        (back_status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .upper_half_o    (upper_half_o),
    .buffer_col_o    (buffer_col_o),
    .buffer_row_o    (buffer_row_o),
    .pixel_color_o   (pixel_color_o),
    .last_o          (last_o)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CntW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.pop |-> (q_count != '0))
    else $error("walker pops an empty queue");

  a_out_from_walker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(back_status.busy))
    else $error("pixel write without an active command");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.pop |=> back_status.busy)
    else $error("walker not busy after loading a command");
`endif

endmodule

FILE: test/led_panel_shape_rasterizer_tb.sv
// Self-checking testbench for the LED panel shape rasterizer: directed and random draw commands vs. a pixel predictor.
`timescale 1ns / 1ps

module led_panel_shape_rasterizer_tb;
  import lpsr_pkg::*;

  typedef struct {
    mode_e             mode;
    logic signed [7:0] ax;
    logic signed [7:0] ay;
    logic [3:0]        eh;
    logic [3:0]        ew;
    logic [2:0]        fc;
    logic [2:0]        bc;
    logic [14:0]       glyph;
    logic              rot;
  } draw_cmd_t;

  typedef struct {
    logic       upper_half;
    logic [1:0] buffer_col;
    logic [7:0] buffer_row;
    logic [2:0] pixel_color;
    logic       last;
  } pixel_wr_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [6:0]        cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  mode_e             mode = ModeFill;
  logic signed [7:0] anchor_x = '0;
  logic signed [7:0] anchor_y = '0;
  logic [3:0]        extent_h = '0;
  logic [3:0]        extent_w = '0;
  logic [2:0]        front_color = '0;
  logic [2:0]        back_color = '0;
  logic [14:0]       glyph_bits = '0;
  logic              rotated = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              upper_half;
  logic [1:0]        buffer_col;
  logic [7:0]        buffer_row;
  logic [2:0]        pixel_color;
  logic              last;

  led_panel_shape_rasterizer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .mode_i       (mode),
    .anchor_x_i   (anchor_x),
    .anchor_y_i   (anchor_y),
    .extent_h_i   (extent_h),
    .extent_w_i   (extent_w),
    .front_color_i(front_color),
    .back_color_i (back_color),
    .glyph_bits_i (glyph_bits),
    .rotated_i    (rotated),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .upper_half_o (upper_half),
    .buffer_col_o (buffer_col),
    .buffer_row_o (buffer_row),
    .pixel_color_o(pixel_color),
    .last_o       (last)
  );

  draw_cmd_t cmd_backlog[$];
  pixel_wr_t pending_pixels[$];
  int        pcols = 16;
  int        fail_count = 0;
  int        cmds_taken = 0;
  int        writes_seen = 0;
  int        settings_used = 1;
  logic      in_fire = 1'b0;
  logic      cfg_fire = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Map one pixel onto the buffer and queue the write.
  task automatic plot(int px, int py, logic [2:0] color);
    logic [3:0]        xb;
    logic signed [7:0] y8;
    int                ys;
    int                seg;
    int                rem;
    int                r;
    pixel_wr_t         w;
    xb = px[3:0];
    y8 = py[7:0];
    ys = y8;
    seg = ys / 8;
    rem = ys % 8;
    if (xb[2]) begin
      r = 2 * pcols - 1 - ys - seg * 8;
    end else begin
      r = 2 * pcols - 16 - seg * 16 + rem;
    end
    w.upper_half  = xb[3];
    w.buffer_col  = xb[1:0];
    w.buffer_row  = r[7:0];
    w.pixel_color = color;
    w.last        = 1'b0;
    pending_pixels.push_back(w);
  endtask

  task automatic rasterize(draw_cmd_t c);
    int ax;
    int ay;
    int eh;
    int ew;
    int h;
    int dr;
    int dc;
    int n;
    ax = c.ax;
    ay = c.ay;
    eh = (c.eh > MaxSide) ? MaxSide : c.eh;
    ew = (c.ew > MaxSide) ? MaxSide : c.ew;
    h  = eh / 2;
    n  = 0;
    case (c.mode)
      ModeFill, ModeBorder: begin
        for (int row = 0; row < eh; row++) begin
          for (int col = 0; col < ew; col++) begin
            if (c.mode == ModeBorder && !(row == 0 || row == eh - 1 || col == 0 ||
                                          col == ew - 1)) continue;
            plot(ax + row, ay + col, c.fc);
            n++;
          end
        end
      end
      ModeCircle: begin
        for (int row = 0; row < eh; row++) begin
          for (int col = 0; col < eh; col++) begin
            dr = row - h;
            dc = col - h;
            plot(ax - h + row, ay - h + col, (dr * dr + dc * dc <= h * h) ? c.fc : c.bc);
            n++;
          end
        end
      end
      default: begin
        for (int row = 0; row < GlyphRows; row++) begin
          for (int col = 0; col < GlyphCols; col++) begin
            if (c.rot) begin
              plot(ax - col, ay + row,
                   c.glyph[(row + 1) * GlyphCols - 1 - col] ? c.fc : 3'd0);
            end else begin
              plot(ax + row, ay + col,
                   c.glyph[(row + 1) * GlyphCols - 1 - col] ? c.fc : 3'd0);
            end
            n++;
          end
        end
      end
    endcase
    if (n > 0) pending_pixels[pending_pixels.size() - 1].last = 1'b1;
  endtask

  task automatic queue_cmd(mode_e m, int ax, int ay, int eh, int ew, int fc, int bc,
                           int glyph, bit rot);
    draw_cmd_t c;
    c.mode  = m;
    c.ax    = ax[7:0];
    c.ay    = ay[7:0];
    c.eh    = eh[3:0];
    c.ew    = ew[3:0];
    c.fc    = fc[2:0];
    c.bc    = bc[2:0];
    c.glyph = glyph[14:0];
    c.rot   = rot;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_random_cmds(int count);
    for (int i = 0; i < count; i++) begin
      // Mostly in-range sides, now and then an oversized one.
      queue_cmd(mode_e'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom_range(0, 255),
                ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8),
                ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8),
                $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 32767),
                $urandom_range(0, 1));
    end
  endtask

  // Wait until every command is taken and every write has come, then let
  // the block idle before the next phase.
  task automatic wait_until_drained();
    do @(posedge clk_i);
    while (cmd_backlog.size() != 0 || in_valid || pending_pixels.size() != 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_columns(logic [6:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk_i);
    while (!cfg_fire);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Sender: bursts of commands separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin : drive_cmds
    logic      nxt_valid;
    draw_cmd_t c;
    if (rst_ni) begin
      nxt_valid = in_valid;
      if (in_valid && in_fire) nxt_valid = 1'b0;
      if (!nxt_valid && cmd_backlog.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          c = cmd_backlog.pop_front();
          mode        <= c.mode;
          anchor_x    <= c.ax;
          anchor_y    <= c.ay;
          extent_h    <= c.eh;
          extent_w    <= c.ew;
          front_color <= c.fc;
          back_color  <= c.bc;
          glyph_bits  <= c.glyph;
          rotated     <= c.rot;
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 6);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Receiver: switches among random stall styles.
  int rdy_style = 0;
  int rdy_cycles = 0;
  int stall_left = 0;

  always @(negedge clk_i) begin : drive_ready
    logic nxt_ready;
    if (rst_ni) begin
      rdy_cycles++;
      if (rdy_cycles == 150) begin
        rdy_cycles = 0;
        rdy_style  = $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else begin
        case (rdy_style)
          0: nxt_ready = 1'b1;
          1: nxt_ready = $urandom_range(0, 1);
          2: nxt_ready = ($urandom_range(0, 3) == 0);
          default: begin
            nxt_ready = 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
          end
        endcase
      end
      out_ready <= nxt_ready;
    end
  end

  always @(posedge clk_i) begin : watch_ports
    draw_cmd_t c;
    pixel_wr_t w;
    in_fire  = in_valid && in_ready;
    cfg_fire = cfg_valid && cfg_ready;
    if (rst_ni) begin
      if (cfg_fire) pcols = cfg_data;
      if (in_fire) begin
        c.mode  = mode;
        c.ax    = anchor_x;
        c.ay    = anchor_y;
        c.eh    = extent_h;
        c.ew    = extent_w;
        c.fc    = front_color;
        c.bc    = back_color;
        c.glyph = glyph_bits;
        c.rot   = rotated;
        rasterize(c);
        cmds_taken++;
      end
      if (out_valid && out_ready) begin
        writes_seen++;
        if (pending_pixels.size() == 0) begin
          note_failure($sformatf("unexpected pixel write: half %0d col %0d row %0d color %0d last %0d",
                                 upper_half, buffer_col, buffer_row, pixel_color, last));
        end else begin
          w = pending_pixels.pop_front();
          if (w.upper_half !== upper_half || w.buffer_col !== buffer_col ||
              w.buffer_row !== buffer_row || w.pixel_color !== pixel_color ||
              w.last !== last) begin
            note_failure($sformatf({"pixel write mismatch: expected half %0d col %0d row %0d ",
                                    "color %0d last %0d, got half %0d col %0d row %0d ",
                                    "color %0d last %0d"},
                                   w.upper_half, w.buffer_col, w.buffer_row, w.pixel_color,
                                   w.last, upper_half, buffer_col, buffer_row, pixel_color,
                                   last));
          end
        end
      end
    end
  end

  initial begin : run_phases
    int col_settings[6];
    col_settings = '{16, 1, 64, 0, 127, 0};
    col_settings[5] = $urandom_range(2, 63);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < 6; p++) begin
      // Phase zero runs on the reset column count.
      if (p > 0) write_columns(col_settings[p][6:0]);
      if (p == 0) begin
        queue_cmd(ModeFill,   -128, 127, 8, 8, 7, 0, 0, 0);
        queue_cmd(ModeFill,   127, -128, 1, 1, 1, 6, 0, 1);
        queue_cmd(ModeFill,   0, 0, 0, 5, 7, 7, 32767, 0);
        queue_cmd(ModeFill,   -1, -1, 3, 0, 2, 1, 0, 0);
        queue_cmd(ModeFill,   5, -3, 15, 12, 4, 3, 0, 0);
        queue_cmd(ModeFill,   8, -8, 8, 8, 0, 7, 0, 0);
        queue_cmd(ModeBorder, 0, 0, 8, 8, 2, 5, 0, 0);
        queue_cmd(ModeBorder, 120, -7, 1, 1, 3, 0, 0, 0);
        queue_cmd(ModeBorder, -9, 8, 2, 5, 5, 0, 0, 0);
        queue_cmd(ModeBorder, 3, 100, 1, 8, 6, 0, 0, 0);
        queue_cmd(ModeBorder, -60, 60, 15, 3, 7, 0, 0, 0);
        queue_cmd(ModeBorder, 4, 4, 8, 1, 1, 0, 0, 0);
        queue_cmd(ModeCircle, 0, 0, 0, 4, 7, 7, 0, 0);
        queue_cmd(ModeCircle, 10, 10, 1, 0, 6, 1, 0, 0);
        queue_cmd(ModeCircle, -5, 127, 2, 0, 5, 2, 0, 0);
        queue_cmd(ModeCircle, 7, -100, 3, 9, 4, 3, 0, 0);
        queue_cmd(ModeCircle, 0, 0, 7, 0, 3, 4, 0, 0);
        queue_cmd(ModeCircle, -128, -128, 8, 8, 7, 0, 0, 0);
        queue_cmd(ModeCircle, 64, 32, 15, 15, 1, 6, 0, 0);
        queue_cmd(ModeGlyph,  0, 0, 3, 3, 7, 0, 32767, 0);
        queue_cmd(ModeGlyph,  127, 127, 3, 3, 7, 5, 0, 1);
        queue_cmd(ModeGlyph,  -128, -2, 0, 0, 6, 0, 21845, 0);
        queue_cmd(ModeGlyph,  15, 7, 0, 0, 5, 2, 10922, 1);
        queue_cmd(ModeGlyph,  -4, -8, 15, 15, 3, 4, 32767, 1);
      end
      queue_random_cmds(39);
      wait_until_drained();
    end

    $display("ran %0d draw commands, %0d pixel writes checked, %0d column count settings",
             cmds_taken, writes_seen, settings_used);
    $display("modes fill, border, circle and glyph with oversized and zero sides covered");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failing pixel writes", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
